@@ sv/bwa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the bridge weight admission block.
// No dependencies; imported by every module of the block except bwa_ram.
package bwa_pkg;

	localparam int TICK_W   = 32;
	localparam int WEIGHT_W = 16;
	localparam int LEN_W    = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CROSSING_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LIMIT    = 1'b1;

	localparam logic [LEN_W-1:0]    LEN_RESET   = 11'd1;
	localparam logic [WEIGHT_W-1:0] LIMIT_RESET = 16'hFFFF;
	localparam logic [TICK_W-1:0]   TICK_MAX    = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [WEIGHT_W-1:0] truck_weight;
		logic                last_truck;
	} in_item_t;

	typedef struct packed {
		logic [TICK_W-1:0] entry_tick;
		logic [TICK_W-1:0] finish_tick;
		logic              batch_done;
		logic              overweight;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic retire;
		logic admit;
		logic bump;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic over;
		logic can_retire;
		logic can_admit;
	} status_t;

	function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] a,
		input logic [TICK_W-1:0] b);
		logic [TICK_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TICK_W] ? TICK_MAX : s[TICK_W-1:0];
	endfunction

endpackage

@@ sv/bridge_weight_admission.sv @@
`timescale 1ns / 1ps
// Top level of the bridge weight admission block: controller plus datapath.
// Depends on bwa_pkg, bwa_ctrl, bwa_dpath (and bwa_ram through the datapath).
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------
//  in      | in_valid / in_ready  | in_item   (truck_weight, last_truck)
//  out     | out_valid / out_ready| out_item  (entry_tick, finish_tick, ...)
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item passes IDLE, READ and CHECK, then FINISH; each truck retired on its
// behalf adds a FIFO RAM read and a check, and each extra wait step a check.
// An overweight truck goes from READ straight to FINISH. Reset clears pointers, count, sum and
// last entry at once; no clearing pass. The next item is taken while a result
// waits; an item finishing behind an untaken result holds until that transfer.
module bridge_weight_admission #(
	parameter int MAX_IN_FLIGHT = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  bwa_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bwa_pkg::out_item_t             out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bwa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bwa_pkg::CFG_DATA_W-1:0] cfg_data
);

	import bwa_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	bwa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bwa_dpath #(
		.MAX_IN_FLIGHT(MAX_IN_FLIGHT)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_item  (in_item),
		.cmd      (cmd),
		.status   (status),
		.out_item (out_item)
	);

endmodule

@@ sv/bwa_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bwa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/bwa_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: sequences load, retire, admit, bump and finish.
// Depends on bwa_pkg.
module bwa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  bwa_pkg::status_t status,
	output bwa_pkg::cmd_t    cmd
);

	import bwa_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = status.over ? ST_FINISH : ST_CHECK;
			end
			ST_CHECK: begin
				if (status.can_retire) begin
					state_d = ST_READ;
				end else if (status.can_admit) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_READ: ;
			ST_CHECK: begin
				cmd.retire = status.can_retire;
				cmd.admit  = !status.can_retire && status.can_admit;
				cmd.bump   = !status.can_retire && !status.can_admit;
			end
			ST_FINISH: begin
				cmd.finish = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/bwa_dpath.sv @@
`timescale 1ns / 1ps
// Datapath: configuration, in-flight FIFO pointers, weight sum, tick and result.
// Depends on bwa_pkg and bwa_ram.
module bwa_dpath #(
	parameter int MAX_IN_FLIGHT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [bwa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bwa_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  bwa_pkg::in_item_t                   in_item,
	input  bwa_pkg::cmd_t                       cmd,
	output bwa_pkg::status_t                    status,
	output bwa_pkg::out_item_t                  out_item
);

	import bwa_pkg::*;

	localparam int AW = $clog2(MAX_IN_FLIGHT);
	localparam int CW = $clog2(MAX_IN_FLIGHT + 1);
	localparam int RW = TICK_W + WEIGHT_W;

	logic [LEN_W-1:0]    len_q;
	logic [WEIGHT_W-1:0] limit_q;
	logic [WEIGHT_W-1:0] w_q;
	logic                last_q;
	logic [TICK_W-1:0]   t_q;
	logic [AW-1:0]       head_q, tail_q;
	logic [CW-1:0]       count_q;
	logic [WEIGHT_W-1:0] sum_q;
	logic [TICK_W-1:0]   last_entry_q;
	out_item_t           out_q;

	logic [RW-1:0]       rdata;
	logic [TICK_W-1:0]   rd_time;
	logic [WEIGHT_W-1:0] rd_weight;
	logic [LEN_W-1:0]    len_eff;
	logic [TICK_W-1:0]   depart;
	logic [WEIGHT_W:0]   sum_new;
	logic [TICK_W-1:0]   finish_val;

	assign rd_time   = rdata[RW-1:WEIGHT_W];
	assign rd_weight = rdata[WEIGHT_W-1:0];
	assign len_eff   = (len_q == '0) ? LEN_W'(1) : len_q;
	assign depart    = sat_add(rd_time, TICK_W'(len_eff));
	assign sum_new   = {1'b0, sum_q} + {1'b0, w_q};

	assign status.over       = w_q > limit_q;
	assign status.can_retire = (count_q != '0) && (depart <= t_q);
	assign status.can_admit  = (count_q != CW'(MAX_IN_FLIGHT)) &&
		(sum_new <= {1'b0, limit_q});

	assign finish_val = (last_entry_q == '0) ? '0 : sat_add(last_entry_q, TICK_W'(len_eff));

	bwa_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_IN_FLIGHT)
	) u_fifo_ram (
		.clk  (clk),
		.we   (cmd.admit),
		.waddr(tail_q),
		.wdata({t_q, w_q}),
		.raddr(head_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= LEN_RESET;
			limit_q      <= LIMIT_RESET;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			last_entry_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_CROSSING_LENGTH: len_q   <= cfg_data[LEN_W-1:0];
					CFG_WEIGHT_LIMIT:    limit_q <= cfg_data[WEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.retire) begin
				head_q  <= (head_q == AW'(MAX_IN_FLIGHT - 1)) ? '0 : head_q + AW'(1);
				count_q <= count_q - CW'(1);
				sum_q   <= sum_q - rd_weight;
			end
			if (cmd.admit) begin
				tail_q       <= (tail_q == AW'(MAX_IN_FLIGHT - 1)) ? '0 : tail_q + AW'(1);
				count_q      <= count_q + CW'(1);
				sum_q        <= sum_new[WEIGHT_W-1:0];
				last_entry_q <= t_q;
			end
			if (cmd.finish && last_q) begin
				head_q       <= '0;
				tail_q       <= '0;
				count_q      <= '0;
				sum_q        <= '0;
				last_entry_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q    <= in_item.truck_weight;
			last_q <= in_item.last_truck;
			t_q    <= sat_add(last_entry_q, TICK_W'(1));
		end else if (cmd.bump) begin
			t_q <= depart;
		end
		if (cmd.finish) begin
			out_q.entry_tick  <= status.over ? '0 : t_q;
			out_q.finish_tick <= last_q ? finish_val : '0;
			out_q.batch_done  <= last_q;
			out_q.overweight  <= status.over;
		end
	end

	assign out_item = out_q;

endmodule

@@ sv/bwa_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the bridge weight admission block, bound to the top level.
// Depends on bwa_pkg and bridge_weight_admission.
module bwa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input bwa_pkg::out_item_t out_item
);

	import bwa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed or vanished before its transfer");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

	a_drop_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.overweight |-> out_item.entry_tick == '0)
		else $error("dropped truck reports an entry tick");

	a_entry_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.overweight |-> out_item.entry_tick != '0)
		else $error("admitted truck reports entry tick zero");

	a_finish_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.batch_done |-> out_item.finish_tick == '0)
		else $error("finish tick outside the last truck");

endmodule

bind bridge_weight_admission bwa_checker u_bwa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);
